### rtl/nmws_pkg.sv
// Package for the newest mappable window selector.
// Holds the event codes, cell commands and the slot and chain types.
// No dependencies.
package nmws_pkg;

  localparam int MAX_CLIENTS = 16;
  localparam int IdW = 32;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_MAP     = 3'd2,
    OP_UNMAP   = 3'd3,
    OP_NONE    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_MAP    = 3'd3,
    CMD_UNMAP  = 3'd4,
    CMD_SELECT = 3'd5
  } cmd_e;

  // One table entry.
  typedef struct packed {
    logic           used;
    logic [IdW-1:0] win;
    logic           mapb;
    logic           shown;
  } slot_t;

  // Running summary handed from a cell to the next (older) one.
  typedef struct packed {
    logic           lk;   // an id match was seen in a newer cell
    logic           sh;   // a shown entry was seen in a newer cell
    logic           mp;   // a mappable entry was seen in a newer cell
    logic [IdW-1:0] cid;  // id of the first shown, else first mappable entry
  } link_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    cmd_e           cmd;
    logic [IdW-1:0] id;
  } cell_ctrl_t;

endpackage

### rtl/nmws_cell.sv
// One table slot of the window selector chain.
// Depends on nmws_pkg for the slot, chain and command types.
module nmws_cell
  import nmws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  slot_t      prev_slot_i,
  input  slot_t      next_slot_i,
  output slot_t      slot_o,
  input  link_t      link_i,
  output link_t      link_o
);

  logic           used_q, mapb_q, shown_q;
  logic [IdW-1:0] win_q;
  slot_t          slot_q, slot_d;
  link_t          link_q;
  logic           match;

  assign slot_q = '{used: used_q, win: win_q, mapb: mapb_q, shown: shown_q};
  assign slot_o = slot_q;
  assign match  = used_q && (win_q == ctrl_i.id);

  always_comb begin
    slot_d = slot_q;
    case (ctrl_i.cmd)
      CMD_INSERT: slot_d = prev_slot_i;
      CMD_REMOVE: begin
        // Every slot at or below the hit takes its older neighbor.
        if (link_q.lk || match) slot_d = next_slot_i;
      end
      CMD_MAP: begin
        if (match && !link_q.lk) slot_d.mapb = 1'b1;
      end
      CMD_UNMAP: begin
        if (match && !link_q.lk) begin
          slot_d.mapb  = 1'b0;
          slot_d.shown = 1'b0;
        end
      end
      CMD_SELECT: begin
        if (used_q && mapb_q && !link_q.mp) slot_d.shown = 1'b1;
      end
      default: slot_d = slot_q;
    endcase
  end

  always_comb begin
    link_o.lk = link_q.lk | match;
    link_o.sh = link_q.sh | (used_q & shown_q);
    link_o.mp = link_q.mp | (used_q & mapb_q);
    if (link_q.sh) begin
      link_o.cid = link_q.cid;
    end else if (used_q && shown_q) begin
      link_o.cid = win_q;
    end else if (link_q.mp) begin
      link_o.cid = link_q.cid;
    end else if (used_q && mapb_q) begin
      link_o.cid = win_q;
    end else begin
      link_o.cid = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      mapb_q  <= 1'b0;
      shown_q <= 1'b0;
      link_q  <= '0;
    end else begin
      used_q  <= slot_d.used;
      mapb_q  <= slot_d.mapb;
      shown_q <= slot_d.shown;
      link_q  <= link_i;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= slot_d.win;
  end

endmodule

### rtl/newest_mappable_window_select.sv
// Newest mappable window selector: top level with the event sequencer and
// the output register. Depends on nmws_pkg and nmws_cell.
//
// The window table is a row of MaxClients cells, newest entry in cell 0,
// kept packed toward cell 0. Each event word (create, destroy, map request,
// unmap notice or no event; codes 5 to 7 count as no event) is taken only
// while the block is idle and yields exactly one result word. Lookups and
// the selection of the newest mappable entry are done by a summary that
// ripples one cell per clock down the row. Destroy, map and unmap take
// two passes: a lookup pass, the table update, then a selection pass.
// Create and no event take one pass: the update, then the selection pass.
// The result then waits until the output register is free. The next
// event is accepted the cycle after the result is loaded into the
// output register, even if that result has not been taken yet.
// A create into a full table is dropped and flagged, and a destroy, map or
// unmap that names no stored window is flagged; in both cases the
// selection still runs.
module newest_mappable_window_select
  import nmws_pkg::*;
#(
  parameter int MaxClients = MAX_CLIENTS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     operation_i,
  input  logic [IdW-1:0] window_id_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           map_issued_o,
  output logic [IdW-1:0] map_target_o,
  output logic           shown_present_o,
  output logic [IdW-1:0] shown_id_o,
  output logic           create_dropped_o,
  output logic           id_unknown_o
);

  localparam int CntW = (MaxClients > 1) ? $clog2(MaxClients) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(MaxClients - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOOK  = 5'b00010,
    ST_APPLY = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_SEL   = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  op_e             op_q, op_in;
  logic [IdW-1:0]  id_q;
  logic            dropped_q, unknown_q;
  logic            dropped_d, unknown_d;

  logic            out_valid_q;
  logic            map_issued_q, shown_present_q, create_dropped_q, id_unknown_q;
  logic [IdW-1:0]  map_target_q, shown_id_q;
  logic            out_load;

  cell_ctrl_t      ctrl;
  slot_t           slot_w [MaxClients];
  link_t           link_w [MaxClients+1];
  slot_t           new_slot;
  logic            table_full, any_match, any_shown, any_mappable, need_sel;

  assign in_ready_o = (state_q == ST_IDLE);

  // Out-of-range codes fall back to no event.
  always_comb begin
    case (operation_i)
      OP_CREATE:  op_in = OP_CREATE;
      OP_DESTROY: op_in = OP_DESTROY;
      OP_MAP:     op_in = OP_MAP;
      OP_UNMAP:   op_in = OP_UNMAP;
      default:    op_in = OP_NONE;
    endcase
  end

  // Row of cells. Cell 0 receives the fresh entry on a create and the
  // oldest cell pulls in an empty slot on a destroy.
  assign new_slot  = '{used: 1'b1, win: id_q, mapb: 1'b0, shown: 1'b0};
  assign link_w[0] = '0;

  for (genvar i = 0; i < MaxClients; i++) begin : g_cell
    slot_t prev_s, next_s;
    if (i == 0) begin : g_first
      assign prev_s = new_slot;
    end else begin : g_mid
      assign prev_s = slot_w[i-1];
    end
    if (i == MaxClients - 1) begin : g_last
      assign next_s = '0;
    end else begin : g_inner
      assign next_s = slot_w[i+1];
    end
    nmws_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_slot_i (prev_s),
      .next_slot_i (next_s),
      .slot_o      (slot_w[i]),
      .link_i      (link_w[i]),
      .link_o      (link_w[i+1])
    );
  end

  // The summary leaving the oldest cell covers the whole table once the
  // ripple has settled.
  assign table_full   = slot_w[MaxClients-1].used;
  assign any_match    = link_w[MaxClients].lk;
  assign any_shown    = link_w[MaxClients].sh;
  assign any_mappable = link_w[MaxClients].mp;
  assign need_sel     = !any_shown && any_mappable;
  assign out_load     = (state_q == ST_SEL) && (!out_valid_q || out_ready_i);

  // Command broadcast to the cells.
  always_comb begin
    ctrl.id  = id_q;
    ctrl.cmd = CMD_HOLD;
    if (state_q == ST_APPLY) begin
      case (op_q)
        OP_CREATE:  ctrl.cmd = table_full ? CMD_HOLD : CMD_INSERT;
        OP_DESTROY: ctrl.cmd = CMD_REMOVE;
        OP_MAP:     ctrl.cmd = CMD_MAP;
        OP_UNMAP:   ctrl.cmd = CMD_UNMAP;
        default:    ctrl.cmd = CMD_HOLD;
      endcase
    end else if (out_load && need_sel) begin
      ctrl.cmd = CMD_SELECT;
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    dropped_d = dropped_q;
    unknown_d = unknown_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          if (op_in == OP_CREATE || op_in == OP_NONE) begin
            state_d = ST_APPLY;
          end else begin
            state_d = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntLast) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        cnt_d     = '0;
        dropped_d = (op_q == OP_CREATE) && table_full;
        unknown_d = (op_q == OP_DESTROY || op_q == OP_MAP || op_q == OP_UNMAP)
                    && !any_match;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntLast) state_d = ST_SEL;
      end
      ST_SEL: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      dropped_q   <= 1'b0;
      unknown_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      dropped_q <= dropped_d;
      unknown_q <= unknown_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Event and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q <= op_in;
      id_q <= window_id_i;
    end
    if (out_load) begin
      map_issued_q     <= need_sel;
      map_target_q     <= need_sel ? link_w[MaxClients].cid : '0;
      shown_present_q  <= any_shown || any_mappable;
      shown_id_q       <= link_w[MaxClients].cid;
      create_dropped_q <= dropped_q;
      id_unknown_q     <= unknown_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign map_issued_o     = map_issued_q;
  assign map_target_o     = map_target_q;
  assign shown_present_o  = shown_present_q;
  assign shown_id_o       = shown_id_q;
  assign create_dropped_o = create_dropped_q;
  assign id_unknown_o     = id_unknown_q;

endmodule

### verif/testbench.sv
// Self-checking testbench for newest_mappable_window_select.
// Depends on nmws_pkg and the block's RTL. A scoreboard class predicts each
// result word from its own copy of the window table; plain tasks drive the event port.
module testbench;
  import nmws_pkg::*;

  // Codes 5 to 7 have no name in the package; the block treats them as no event.
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;
  localparam int DrainCycles = 2 * MAX_CLIENTS + 8;
  localparam int RandomEvents = 1900;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic           map_issued;
    logic [IdW-1:0] map_target;
    logic           shown_present;
    logic [IdW-1:0] shown_id;
    logic           create_dropped;
    logic           id_unknown;
  } sel_word_t;

  // Tracks the window table, predicts one result word per accepted event
  // word and compares the block's result words against those predictions.
  class window_selection_checker;
    bit             used [MAX_CLIENTS];
    bit [IdW-1:0]   win [MAX_CLIENTS];
    bit             mapb [MAX_CLIENTS];
    bit             shown [MAX_CLIENTS];
    sel_word_t      pending_words [$];
    int             n_errors;
    int             n_checked;
    int             n_events [8];
    int             n_maps;
    int             n_dropped;
    int             n_unknown;

    function int occupancy();
      int cnt;
      cnt = 0;
      for (int i = 0; i < MAX_CLIENTS; i++) cnt += int'(used[i]);
      return cnt;
    endfunction

    function logic [IdW-1:0] entry_id(int slot);
      return win[slot];
    endfunction

    // Newest used entry holding this id, or -1.
    function int find_newest(logic [IdW-1:0] id);
      int hit;
      hit = -1;
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        if (hit < 0 && used[i] && win[i] == id) hit = i;
      end
      return hit;
    endfunction

    function void predict_event(logic [2:0] op, logic [IdW-1:0] id);
      sel_word_t r;
      int        hit;
      r = '0;
      n_events[op]++;
      case (op)
        OP_CREATE: begin
          if (used[MAX_CLIENTS-1]) begin
            r.create_dropped = 1'b1;
          end else begin
            // Everything moves one place older to make room at the front.
            for (int i = MAX_CLIENTS - 1; i > 0; i--) begin
              used[i] = used[i-1];
              win[i] = win[i-1];
              mapb[i] = mapb[i-1];
              shown[i] = shown[i-1];
            end
            used[0] = 1'b1;
            win[0] = id;
            mapb[0] = 1'b0;
            shown[0] = 1'b0;
          end
        end
        OP_DESTROY, OP_MAP, OP_UNMAP: begin
          hit = find_newest(id);
          if (hit < 0) begin
            r.id_unknown = 1'b1;
          end else if (op == OP_DESTROY) begin
            // Close the gap so the table stays packed toward the front.
            for (int i = hit; i < MAX_CLIENTS - 1; i++) begin
              used[i] = used[i+1];
              win[i] = win[i+1];
              mapb[i] = mapb[i+1];
              shown[i] = shown[i+1];
            end
            used[MAX_CLIENTS-1] = 1'b0;
            win[MAX_CLIENTS-1] = '0;
            mapb[MAX_CLIENTS-1] = 1'b0;
            shown[MAX_CLIENTS-1] = 1'b0;
          end else if (op == OP_MAP) begin
            mapb[hit] = 1'b1;
          end else begin
            mapb[hit] = 1'b0;
            shown[hit] = 1'b0;
          end
        end
        default: ;
      endcase

      // With nothing shown, the newest mappable entry gets selected.
      hit = -1;
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        if (hit < 0 && used[i] && shown[i]) hit = i;
      end
      if (hit < 0) begin
        for (int i = 0; i < MAX_CLIENTS; i++) begin
          if (hit < 0 && used[i] && mapb[i]) begin
            shown[i] = 1'b1;
            r.map_issued = 1'b1;
            r.map_target = win[i];
            hit = i;
          end
        end
      end
      if (hit >= 0) begin
        r.shown_present = 1'b1;
        r.shown_id = win[hit];
      end
      n_maps += int'(r.map_issued);
      n_dropped += int'(r.create_dropped);
      n_unknown += int'(r.id_unknown);
      pending_words.push_back(r);
    endfunction

    task report_mismatch(string what, logic [IdW-1:0] got, logic [IdW-1:0] want);
      n_errors++;
      $display("MISMATCH result %0d: %s got %h, wanted %h", n_checked, what, got, want);
    endtask

    task compare_field(string what, logic [IdW-1:0] got, logic [IdW-1:0] want);
      if (got !== want) report_mismatch(what, got, want);
    endtask

    task check_word(sel_word_t got);
      sel_word_t want;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected result word, shown_id", got.shown_id, '0);
      end else begin
        want = pending_words.pop_front();
        compare_field("map_issued", IdW'(got.map_issued), IdW'(want.map_issued));
        compare_field("map_target", got.map_target, want.map_target);
        compare_field("shown_present", IdW'(got.shown_present),
                      IdW'(want.shown_present));
        compare_field("shown_id", got.shown_id, want.shown_id);
        compare_field("create_dropped", IdW'(got.create_dropped),
                      IdW'(want.create_dropped));
        compare_field("id_unknown", IdW'(got.id_unknown), IdW'(want.id_unknown));
      end
      n_checked++;
    endtask
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  logic [2:0]     operation_i = OP_NONE;
  logic [IdW-1:0] window_id_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  logic           map_issued_o;
  logic [IdW-1:0] map_target_o;
  logic           shown_present_o;
  logic [IdW-1:0] shown_id_o;
  logic           create_dropped_o;
  logic           id_unknown_o;

  window_selection_checker sb = new();

  // Sender pacing: words go out in bursts, with idle gaps in between.
  int burst_left = 0;
  // Ids shared among creates so that duplicate ids pile up in the table.
  logic [IdW-1:0] id_pool [6];

  newest_mappable_window_select u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .window_id_i     (window_id_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .map_issued_o    (map_issued_o),
    .map_target_o    (map_target_o),
    .shown_present_o (shown_present_o),
    .shown_id_o      (shown_id_o),
    .create_dropped_o(create_dropped_o),
    .id_unknown_o    (id_unknown_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(8 * 1_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one event word and holds it until the block takes it. Called at a
  // rising edge; the handshake is sampled right after each edge.
  task automatic send_event(input logic [2:0] op, input logic [IdW-1:0] id);
    in_valid_i <= 1'b1;
    operation_i <= op;
    window_id_i <= id;
    do @(posedge clk_i); while (!in_ready_o);
    sb.predict_event(op, id);
  endtask

  // After each word, either keep the burst going or drop valid for a while.
  task automatic issue(input logic [2:0] op, input logic [IdW-1:0] id);
    int gap;
    send_event(op, id);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Mostly well-formed traffic: destroy, map and unmap usually name a stored
  // window. Phases alternate between filling and draining the table.
  task automatic random_event(input int n, output logic [2:0] op, output logic [IdW-1:0] id);
    int occ;
    int roll;
    int create_pct;
    int kind;
    occ = sb.occupancy();
    roll = $urandom_range(0, 99);
    create_pct = ((n / 150) % 2 == 0) ? 40 : 12;
    if ($urandom_range(0, 19) == 0) id_pool[$urandom_range(0, 5)] = $urandom;
    if (roll < create_pct) begin
      op = OP_CREATE;
      id = ($urandom_range(0, 3) == 0) ? $urandom : id_pool[$urandom_range(0, 5)];
    end else if (roll < create_pct + 52) begin
      kind = $urandom_range(0, 9);
      op = (kind < 3) ? OP_DESTROY : (kind < 7) ? OP_MAP : OP_UNMAP;
      if (occ > 0 && $urandom_range(0, 99) < 85)
        id = sb.entry_id($urandom_range(0, occ - 1));
      else
        id = ($urandom_range(0, 1) == 0) ? $urandom : id_pool[$urandom_range(0, 5)];
    end else if (roll < 97) begin
      op = OP_NONE;
      id = $urandom;
    end else begin
      op = 3'($urandom_range(OpSpareLo, OpSpareHi));
      id = $urandom;
    end
  endtask

  // Receiver: its own ready pattern, drawn at random from four modes, plus two long
  // hold-offs that let the block back up and stall its input.
  initial begin
    int        mode;
    int        phase;
    int        holds_done;
    sel_word_t got;
    mode = 0;
    phase = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.map_issued = map_issued_o;
        got.map_target = map_target_o;
        got.shown_present = shown_present_o;
        got.shown_id = shown_id_o;
        got.create_dropped = create_dropped_o;
        got.id_unknown = id_unknown_o;
        sb.check_word(got);
      end
      if (holds_done < 2 && sb.n_checked >= 500 + 800 * holds_done) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (phase == 0) mode = $urandom_range(0, 3);
        phase = (phase + 1) % 64;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 0);
          2: out_ready_i <= ($urandom_range(0, 5) == 0);
          default: out_ready_i <= (phase % 16) < 10;
        endcase
      end
    end
  end

  initial begin
    logic [2:0]     op;
    logic [IdW-1:0] id;
    for (int i = 0; i < 6; i++) id_pool[i] = $urandom;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: empty table, id extremes, duplicates, losing the
    // shown window by unmap and by destroy, the unused codes, then a full
    // table and a dropped create.
    issue(OP_NONE, '0);
    issue(OP_DESTROY, 32'h0000_0123);
    issue(OP_CREATE, '0);
    issue(OP_CREATE, '1);
    issue(OP_MAP, '1);
    issue(OP_CREATE, '0);
    issue(OP_MAP, '0);
    issue(OP_UNMAP, '1);
    issue(OP_DESTROY, '0);
    issue(OpSpareLo, 32'hAAAA_AAAA);
    issue(3'd6, 32'h5555_5555);
    issue(OpSpareHi, '1);
    issue(OP_MAP, '0);
    for (int i = 0; i < MAX_CLIENTS - 1; i++) begin
      issue(OP_CREATE, (i % 2 == 0) ? 32'hAAAA_AAAA ^ i : 32'h5555_5555 ^ i);
    end

    for (int n = 0; n < RandomEvents; n++) begin
      random_event(n, op, id);
      issue(op, id);
    end
    in_valid_i <= 1'b0;

    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d creates, %0d destroys, %0d map requests, %0d unmap notices,",
             sb.n_events[OP_CREATE], sb.n_events[OP_DESTROY], sb.n_events[OP_MAP],
             sb.n_events[OP_UNMAP]);
    $display("%0d idle words; %0d results checked, %0d map commands, %0d drops, %0d unknown ids",
             sb.n_events[OP_NONE] + sb.n_events[5] + sb.n_events[6] + sb.n_events[7],
             sb.n_checked, sb.n_maps, sb.n_dropped, sb.n_unknown);
    if (sb.n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
